/* hw/rtl/ttf_pkg.sv */
// Package for the tip taper function unit: widths, register indexes,
// sequencer states, divider status and constant-root functions.
// No dependencies.
package ttf_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ITER_COUNT_DEF = 20;

    localparam int POS_W      = 17;
    localparam int FACTOR_W   = 18;
    localparam int ETA_W      = 12;
    localparam int TBRK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TBRK = 2'd2;

    localparam logic [POS_W-1:0]    ONE_Q16    = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX = 18'h3FFFF;
    localparam logic [ETA_W-1:0]    ETA_RESET  = 12'd256;
    localparam logic [TBRK_W-1:0]   TBRK_RESET = 16'd52429;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV, ST_UU, ST_EU, ST_EE, ST_EEK, ST_POLY, ST_NORM, ST_SQ,
        ST_SQR, ST_LOGE, ST_PQ, ST_EXP, ST_EXPR, ST_SHR, ST_FMUL, ST_FRES, ST_OUT
    } ttf_state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } ttf_div_stat_t;

    function automatic logic [63:0] ttf_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = v;
        for (int n = 0; n < 32; n++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int n = 0; n < 32; n++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // root for exp2 step j: 2^(-2^-(j+1)) in Qw
    function automatic logic [63:0] ttf_root(input int w, input int j);
        logic [63:0] r;
        r = 64'd1 << (w - 1);
        for (int i = 0; i <= j; i++) begin
            r = ttf_isqrt(r << w);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ttf_mul.sv */
// Shared multiplier with registered product.
// Depends on nothing but its parameters.
module ttf_mul #(
    parameter int MW = 25
) (
    input  logic            aclk,
    input  logic [MW-1:0]   mul_a,
    input  logic [MW-1:0]   mul_b,
    output logic [2*MW-1:0] mul_p
);

    logic [2*MW-1:0] prod_reg;
    logic [2*MW-1:0] prod_next;

    assign prod_next = (2*MW)'(mul_a) * (2*MW)'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_p = prod_reg;

endmodule

/* hw/rtl/ttf_div.sv */
// Bit-serial restoring divider: quotient of num * 2^W / den, num <= den.
// Depends on ttf_pkg.
module ttf_div
    import ttf_pkg::*;
#(
    parameter int W = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] num,
    input  logic [POS_W-1:0] den,
    output logic [W:0]       quo,
    output ttf_div_stat_t    stat
);

    localparam int CW = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] den_reg, den_next;
    logic [W:0]       quo_reg, quo_next;
    logic [POS_W:0]   sh;

    assign sh = {rem_reg, 1'b0};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            if (num >= den) begin
                rem_next = num - den;
                quo_next = (W+1)'(1);
            end else begin
                rem_next = num;
                quo_next = '0;
            end
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = POS_W'(sh - {1'b0, den_reg});
                quo_next = {quo_reg[W-1:0], 1'b1};
            end else begin
                rem_next = POS_W'(sh);
                quo_next = {quo_reg[W-1:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quo         = quo_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = (rem_reg != '0);

endmodule

/* hw/rtl/tip_taper_function_unit.sv */
// Tip taper function unit: sequencer, config registers and output register.
// The constant region goes straight to the output register, and a zero base skips
// the normalize, squaring and exp2 steps. Otherwise the time is set by the serial
// divider, the normalize shift and the squaring and exp2 steps on the shared multiplier.
// One item at a time: the next is taken once the result is in the output register.
// Reset: side 0, eta 1.0, t_break about 0.8. Depends on ttf_pkg, ttf_div, ttf_mul.
module tip_taper_function_unit
    import ttf_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ITER_COUNT = ITER_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [POS_W-1:0]      s_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FACTOR_W-1:0]   m_factor,
    output logic                  m_saturated
);

    localparam int W    = FRAC_BITS;
    localparam int MW   = (W + 8 > 25) ? W + 8 : 25;
    localparam int KW   = $clog2(W + 1);
    localparam int LW   = KW + W;
    localparam int PIW  = 4 + KW;
    localparam int PLW  = W + 8;
    localparam int CW   = $clog2(ITER_COUNT);
    localparam int JW   = $clog2(W);
    localparam int FW   = W + 9;
    localparam int F16W = (W >= 16) ? FW : 25;
    localparam logic [W+1:0] ONE = (W+2)'(1) << W;

    ttf_state_t state_reg, state_next;

    logic                side_reg, side_next;
    logic [ETA_W-1:0]    eta_reg, eta_next;
    logic [TBRK_W-1:0]   tbrk_reg, tbrk_next;

    logic [W:0]          x_reg, x_next;
    logic [W:0]          u_reg, u_next;
    logic [W:0]          u2_reg, u2_next;
    logic [PLW-1:0]      poly_reg, poly_next;
    logic [W+1:0]        m_reg, m_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [ITER_COUNT-1:0] g_reg, g_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [W-1:0]        q_reg, q_next;
    logic [PIW-1:0]      pi_reg, pi_next;
    logic [W:0]          acc_reg, acc_next;
    logic [JW-1:0]       j_reg, j_next;
    logic [W:0]          pw_reg, pw_next;
    logic [FACTOR_W-1:0] res_f_reg, res_f_next;
    logic                res_s_reg, res_s_next;
    logic                mv_reg, mv_next;
    logic [FACTOR_W-1:0] mf_reg, mf_next;
    logic                ms_reg, ms_next;

    logic [POS_W-1:0]    t_cl, t0, num, den;
    logic                konst, accept, div_start;
    logic [W:0]          div_quo;
    ttf_div_stat_t       div_stat;
    logic [MW-1:0]       mul_a, mul_b;
    logic [2*MW-1:0]     mul_p;
    logic [W-1:0]        g_al;
    logic [LW-1:0]       lval;
    logic [W+1:0]        m2;
    logic [3+LW:0]       pp;
    logic [FW-1:0]       fval;
    logic [F16W-1:0]     f16;
    logic [W-1:0]        root_tab [W];

    for (genvar j = 0; j < W; j++) begin : g_root
        assign root_tab[j] = W'(ttf_root(W, j));
    end

    if (ITER_COUNT >= FRAC_BITS) begin : g_al_tr
        assign g_al = g_reg[ITER_COUNT-1 -: FRAC_BITS];
    end else begin : g_al_zf
        assign g_al = {g_reg, {(FRAC_BITS - ITER_COUNT){1'b0}}};
    end

    assign fval = mul_p[W +: FW];
    if (W >= 16) begin : g_f_tr
        assign f16 = F16W'(fval >> (W - 16));
    end else begin : g_f_zf
        assign f16 = {fval, {(16 - W){1'b0}}};
    end

    assign lval = {k_reg, {W{1'b0}}} - LW'(g_al);
    assign m2   = mul_p[W +: W+2];
    assign pp   = mul_p[8 +: 4+LW];

    assign accept = s_valid && s_ready;
    assign t_cl   = (s_position > ONE_Q16) ? ONE_Q16 : s_position;
    assign t0     = (tbrk_reg == '0) ? POS_W'(1) : {1'b0, tbrk_reg};

    always_comb begin
        if (!side_reg) begin
            konst = t_cl < t0;
            num   = ONE_Q16 - t_cl;
            den   = ONE_Q16 - t0;
        end else begin
            konst = t_cl > t0;
            num   = t_cl;
            den   = t0;
        end
    end

    ttf_div #(.W(W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    ttf_mul #(.MW(MW)) u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = konst ? ST_OUT : ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_UU;
            ST_UU:   state_next = ST_EU;
            ST_EU:   state_next = ST_EE;
            ST_EE:   state_next = ST_EEK;
            ST_EEK:  state_next = ST_POLY;
            ST_POLY: state_next = (x_reg == '0) ? ST_FMUL : ST_NORM;
            ST_NORM: if (m_reg >= ONE) state_next = ST_SQ;
            ST_SQ:   state_next = ST_SQR;
            ST_SQR:  state_next = (cnt_reg == CW'(ITER_COUNT - 1)) ? ST_LOGE : ST_SQ;
            ST_LOGE: state_next = ST_PQ;
            ST_PQ:   state_next = ST_EXP;
            ST_EXP: begin
                if (q_reg[W-1]) state_next = ST_EXPR;
                else if (j_reg == JW'(W - 1)) state_next = ST_SHR;
            end
            ST_EXPR: state_next = (j_reg == JW'(W - 1)) ? ST_SHR : ST_EXP;
            ST_SHR:  state_next = ST_FMUL;
            ST_FMUL: state_next = ST_FRES;
            ST_FRES: state_next = ST_OUT;
            ST_OUT:  if (!mv_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_IDLE) && s_valid && !konst;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_UU:   begin mul_a = MW'(u_reg);   mul_b = MW'(u_reg);  end
            ST_EU:   begin mul_a = MW'(eta_reg); mul_b = MW'(u_reg);  end
            ST_EE: begin
                mul_a = MW'(eta_reg);
                mul_b = MW'({1'b0, eta_reg} + 13'd256);
            end
            ST_EEK:  begin mul_a = MW'(mul_p[24:0]); mul_b = MW'(u2_reg); end
            ST_SQ:   begin mul_a = MW'(m_reg);   mul_b = MW'(m_reg);  end
            ST_LOGE: begin mul_a = MW'(eta_reg); mul_b = MW'(lval);   end
            ST_EXP:  begin mul_a = MW'(acc_reg); mul_b = MW'(root_tab[j_reg]); end
            ST_FMUL: begin mul_a = MW'(pw_reg);  mul_b = MW'(poly_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // datapath
    always_comb begin
        side_next  = side_reg;
        eta_next   = eta_reg;
        tbrk_next  = tbrk_reg;
        x_next     = x_reg;
        u_next     = u_reg;
        u2_next    = u2_reg;
        poly_next  = poly_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        pi_next    = pi_reg;
        acc_next   = acc_reg;
        j_next     = j_reg;
        pw_next    = pw_reg;
        res_f_next = res_f_reg;
        res_s_next = res_s_reg;
        mv_next    = mv_reg;
        mf_next    = mf_reg;
        ms_next    = ms_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SIDE: side_next = cfg_wdata[0];
                CFG_ETA:  eta_next  = cfg_wdata[ETA_W-1:0];
                CFG_TBRK: tbrk_next = cfg_wdata[TBRK_W-1:0];
                default:  side_next = side_reg;
            endcase
        end

        if (mv_reg && m_ready) mv_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                res_f_next = FACTOR_W'(ONE_Q16);
                res_s_next = 1'b0;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    x_next = div_quo;
                    u_next = (W+1)'(ONE) - div_quo - (W+1)'(div_stat.rem_nz);
                    m_next = (W+2)'(div_quo);
                    k_next = '0;
                    g_next = '0;
                    cnt_next = '0;
                end
            end
            ST_EU:   u2_next = mul_p[W +: W+1];
            ST_EE:   poly_next = PLW'(ONE) + PLW'(mul_p[8 +: W+4]);
            ST_POLY: begin
                poly_next = poly_reg + mul_p[17 +: PLW];
                pw_next   = (eta_reg == '0) ? (W+1)'(ONE) : '0;
            end
            ST_NORM: begin
                if (m_reg < ONE) begin
                    m_next = {m_reg[W:0], 1'b0};
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SQR: begin
                if (m2[W+1]) begin
                    g_next = {g_reg[ITER_COUNT-2:0], 1'b1};
                    m_next = m2 >> 1;
                end else begin
                    g_next = {g_reg[ITER_COUNT-2:0], 1'b0};
                    m_next = m2;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_PQ: begin
                q_next   = pp[W-1:0];
                pi_next  = pp[W +: PIW];
                acc_next = (W+1)'(ONE);
                j_next   = '0;
            end
            ST_EXP: begin
                if (!q_reg[W-1]) begin
                    q_next = q_reg << 1;
                    j_next = j_reg + 1'b1;
                end
            end
            ST_EXPR: begin
                acc_next = mul_p[W +: W+1];
                q_next   = q_reg << 1;
                j_next   = j_reg + 1'b1;
            end
            ST_SHR:  pw_next = (pi_reg > PIW'(W)) ? '0 : (acc_reg >> pi_reg);
            ST_FRES: begin
                if (f16 > F16W'(FACTOR_MAX)) begin
                    res_f_next = FACTOR_MAX;
                    res_s_next = 1'b1;
                end else begin
                    res_f_next = f16[FACTOR_W-1:0];
                    res_s_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    mf_next = res_f_reg;
                    ms_next = res_s_reg;
                end
            end
            default: x_next = x_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            side_reg  <= 1'b0;
            eta_reg   <= ETA_RESET;
            tbrk_reg  <= TBRK_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
            eta_reg   <= eta_next;
            tbrk_reg  <= tbrk_next;
            mv_reg    <= mv_next;
        end
        x_reg     <= x_next;
        u_reg     <= u_next;
        u2_reg    <= u2_next;
        poly_reg  <= poly_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        g_reg     <= g_next;
        cnt_reg   <= cnt_next;
        q_reg     <= q_next;
        pi_reg    <= pi_next;
        acc_reg   <= acc_next;
        j_reg     <= j_next;
        pw_reg    <= pw_next;
        res_f_reg <= res_f_next;
        res_s_reg <= res_s_next;
        mf_reg    <= mf_next;
        ms_reg    <= ms_next;
    end

    assign m_valid     = mv_reg;
    assign m_factor    = mf_reg;
    assign m_saturated = ms_reg;

endmodule
